>>> hw/rtl/vpf_pkg.sv
// ----------------------------------------------------------------------------
// vpf_pkg - shared types and constants for the pixel format converter
// Source format codes, word layouts, queue sizing and BT.601 coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package vpf_pkg;

    typedef enum logic [1:0] {
        FMT_RGB32 = 2'd0,
        FMT_RGB24 = 2'd1,
        FMT_YUY2  = 2'd2,
        FMT_NV12  = 2'd3
    } t_src_fmt;

    // source pixel group
    typedef struct packed {
        logic [7:0] lane0;
        logic [7:0] lane1;
        logic [7:0] lane2;
        logic [7:0] lane3;
        logic [7:0] lane4;
        logic [7:0] lane5;
        logic       row_end_in;
        logic       frame_end_in;
    } t_in_word;

    // one XRGB pixel
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] pad_byte;
        logic       lower_row;
        logic       column_offset;
        logic       last_of_run;
        logic       row_end_out;
        logic       frame_end_out;
    } t_out_word;

    // classified item as held in the queue
    typedef struct packed {
        t_src_fmt   fmt;
        logic [1:0] last_idx;   // index of the final pixel of the item
        t_in_word   src;
    } t_job;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam int ProdW = 19;  // holds every coefficient product
    localparam int SumW  = 20;  // holds every weighted sum

    localparam logic signed [ProdW-1:0] CoefY  = 19'sd298;
    localparam logic signed [ProdW-1:0] CoefRe = 19'sd409;
    localparam logic signed [ProdW-1:0] CoefGd = 19'sd100;
    localparam logic signed [ProdW-1:0] CoefGe = 19'sd208;
    localparam logic signed [ProdW-1:0] CoefBd = 19'sd516;
    localparam logic signed [SumW-1:0]  Round  = 20'sd128;
    localparam logic signed [8:0]       LumaOffset   = 9'sd16;
    localparam logic signed [8:0]       ChromaOffset = 9'sd128;
    localparam logic [7:0]              OpaquePad    = 8'd255;

endpackage

`default_nettype wire

>>> hw/rtl/vpf_ifs.sv
// ----------------------------------------------------------------------------
// vpf_ifs - handshake channels of the pixel format converter
// Source pixel channel, output pixel channel and register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface vpf_in_if import vpf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vpf_out_if import vpf_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface vpf_cfg_if ();
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/vpf_front.sv
// ----------------------------------------------------------------------------
// vpf_front - accept and classify source words
// Holds the format register and tags each word with the index of its last pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module vpf_front import vpf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    vpf_in_if.sink     i_pix,
    vpf_cfg_if.sink    i_cfg,
    input  wire        i_q_full,
    output logic       o_q_push,
    output t_job       o_q_job
);

    t_src_fmt r_fmt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_RGB32;
        end else if (i_cfg.valid) begin
            r_fmt <= t_src_fmt'(i_cfg.data);
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = !i_q_full;
    assign o_q_push    = i_pix.valid && !i_q_full;

    always_comb begin
        o_q_job.fmt = r_fmt;
        o_q_job.src = i_pix.data;
        case (r_fmt)
            FMT_YUY2: o_q_job.last_idx = 2'd1;
            FMT_NV12: o_q_job.last_idx = 2'd3;
            default:  o_q_job.last_idx = 2'd0;
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/vpf_queue.sv
// ----------------------------------------------------------------------------
// vpf_queue - short job queue between front and back
// Register-based FIFO of classified words; head shown combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module vpf_queue import vpf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_push,
    input  t_job       i_job,
    input  wire        i_pop,
    output logic       o_full,
    output logic       o_head_valid,
    output t_job       o_head
);

    t_job                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr;
    logic [QueuePtrW-1:0] r_rd;
    logic [QueueCntW-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full       = (r_count == QueueCntW'(QueueDepth));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QueuePtrW'(QueueDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QueuePtrW'(QueueDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/vpf_back.sv
// ----------------------------------------------------------------------------
// vpf_back - pixel sequencer and colour conversion
// Walks the pixels of the head job, one a cycle unless the output stalls,
// through product and sum/clamp stages into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vpf_back import vpf_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_head_valid,
    input  t_job       i_head,
    output logic       o_pop,
    vpf_out_if.source  o_pix
);

    function automatic logic [7:0] clamp8(input logic signed [SumW-1:0] s);
        logic [7:0] res;
        if (s[SumW-1]) begin
            res = 8'd0;
        end else if (s[SumW-2:16] != '0) begin
            res = 8'd255;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    logic [1:0] r_pix;
    logic       adv;
    logic       pix_last;
    logic       is_yuv;
    logic [7:0] sel_y;
    logic [7:0] sel_cb;
    logic [7:0] sel_cr;
    logic signed [8:0]       c9, d9, e9;
    logic signed [ProdW-1:0] c19, d19, e19;

    // product stage
    logic                    r_s1_valid;
    logic                    r_s1_yuv;
    logic [7:0]              r_s1_r, r_s1_g, r_s1_b, r_s1_pad;
    logic signed [ProdW-1:0] r_s1_pyc, r_s1_pre, r_s1_pgd, r_s1_pge, r_s1_pbd;
    logic                    r_s1_lower, r_s1_col, r_s1_last, r_s1_rowe, r_s1_frme;

    // output stage
    logic                    r_s2_valid;
    t_out_word               r_s2;
    logic signed [SumW-1:0]  sum_r, sum_g, sum_b;

    assign adv      = !r_s2_valid || o_pix.ready;
    assign pix_last = (r_pix == i_head.last_idx);
    assign o_pop    = i_head_valid && adv && pix_last;
    assign is_yuv   = (i_head.fmt == FMT_YUY2) || (i_head.fmt == FMT_NV12);

    always_comb begin
        case (i_head.fmt)
            FMT_YUY2: sel_y = r_pix[0] ? i_head.src.lane2 : i_head.src.lane0;
            FMT_NV12: begin
                case (r_pix)
                    2'd0:    sel_y = i_head.src.lane0;
                    2'd1:    sel_y = i_head.src.lane1;
                    2'd2:    sel_y = i_head.src.lane2;
                    default: sel_y = i_head.src.lane3;
                endcase
            end
            default:  sel_y = i_head.src.lane0;
        endcase
        sel_cb = (i_head.fmt == FMT_NV12) ? i_head.src.lane4 : i_head.src.lane1;
        sel_cr = (i_head.fmt == FMT_NV12) ? i_head.src.lane5 : i_head.src.lane3;
    end

    assign c9  = $signed({1'b0, sel_y}) - LumaOffset;
    assign d9  = $signed({1'b0, sel_cb}) - ChromaOffset;
    assign e9  = $signed({1'b0, sel_cr}) - ChromaOffset;
    assign c19 = ProdW'(c9);
    assign d19 = ProdW'(d9);
    assign e19 = ProdW'(e9);

    // advance the pixel index; clear it when the job leaves the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= 2'd0;
        end else if (i_head_valid && adv) begin
            r_pix <= pix_last ? 2'd0 : r_pix + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_head_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_head_valid) begin
            r_s1_yuv   <= is_yuv;
            r_s1_r     <= i_head.src.lane2;
            r_s1_g     <= i_head.src.lane1;
            r_s1_b     <= i_head.src.lane0;
            r_s1_pad   <= (i_head.fmt == FMT_RGB32) ? i_head.src.lane3 :
                          (i_head.fmt == FMT_RGB24) ? OpaquePad : 8'd0;
            r_s1_pyc   <= c19 * CoefY;
            r_s1_pre   <= e19 * CoefRe;
            r_s1_pgd   <= d19 * CoefGd;
            r_s1_pge   <= e19 * CoefGe;
            r_s1_pbd   <= d19 * CoefBd;
            r_s1_lower <= (i_head.fmt == FMT_NV12) && r_pix[1];
            r_s1_col   <= is_yuv && r_pix[0];
            r_s1_last  <= pix_last;
            r_s1_rowe  <= pix_last && i_head.src.row_end_in;
            r_s1_frme  <= pix_last && i_head.src.frame_end_in;
        end
    end

    assign sum_r = SumW'(r_s1_pyc) + SumW'(r_s1_pre) + Round;
    assign sum_g = SumW'(r_s1_pyc) - SumW'(r_s1_pgd) - SumW'(r_s1_pge) + Round;
    assign sum_b = SumW'(r_s1_pyc) + SumW'(r_s1_pbd) + Round;

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_s2.red           <= r_s1_yuv ? clamp8(sum_r) : r_s1_r;
            r_s2.green         <= r_s1_yuv ? clamp8(sum_g) : r_s1_g;
            r_s2.blue          <= r_s1_yuv ? clamp8(sum_b) : r_s1_b;
            r_s2.pad_byte      <= r_s1_pad;
            r_s2.lower_row     <= r_s1_lower;
            r_s2.column_offset <= r_s1_col;
            r_s2.last_of_run   <= r_s1_last;
            r_s2.row_end_out   <= r_s1_rowe;
            r_s2.frame_end_out <= r_s1_frme;
        end
    end

    assign o_pix.valid = r_s2_valid;
    assign o_pix.data  = r_s2;

`ifndef NO_ASSERTIONS
    a_pix_clear_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_pix == 2'd0))
        else $error("pixel index not cleared after job pop");

    a_pix_mid_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pix != 2'd0) |-> i_head_valid)
        else $error("pixel index mid-job with no job at queue head");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !adv) |=> r_s1_valid)
        else $error("product stage dropped a pixel during stall");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/video_pixel_format_to_rgb32.sv
// ----------------------------------------------------------------------------
// video_pixel_format_to_rgb32 - source pixel groups to 32-bit XRGB
// RGB32 copy, RGB24 pack, YUY2 and NV12 via integer BT.601 with clamping.
// ----------------------------------------------------------------------------
//
//  channel   dir  word                        accepted when
//  i_pix     in   lanes 0..5, row/frame end   i_pix.valid && i_pix.ready
//  o_pix     out  one XRGB pixel + markers    o_pix.valid && o_pix.ready
//  i_cfg     in   source_format (2 bits)      i_cfg.valid && i_cfg.ready
//
//  Output runs at one pixel per cycle while o_pix is not stalled; an item holds
//  1 (RGB), 2 (YUY2) or 4 (NV12) pixels for the back sequencer, which sets the item rate.
//  First pixel passes the job queue, product stage and output register to o_pix.
//  A 4-deep job queue lets the front keep accepting while the back stalls.
//  Synchronous active-low reset clears format to RGB32 and empties the pipe.
//  i_cfg is always ready; write it only while the block is idle.
//
`default_nettype none

module video_pixel_format_to_rgb32 import vpf_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    vpf_in_if.sink      i_pix,
    vpf_cfg_if.sink     i_cfg,
    vpf_out_if.source   o_pix
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_head_valid;
    t_job q_job;
    t_job q_head;

    // accept and classify; format register lives here
    vpf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pix    (i_pix),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_job)
    );

    // decouple front from back
    vpf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (q_job),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // walk pixels, convert, hold result in the output register
    vpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_pix        (o_pix)
    );

endmodule

`default_nettype wire
